// File: rtl/f2i_pkg.sv
// Package for the saturating float-to-integer converter.
// Holds stage payload types and bound constants.
// No dependencies.
package f2i_pkg;

  localparam logic [63:0] I32_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] I32_MIN = 64'h0000_0000_8000_0000;
  localparam logic [63:0] U32_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] src_bits;
  } in_word_t;

  typedef struct packed {
    logic        is_unsigned;
    logic        wide;
    logic        neg;
    logic        nan;
    logic        huge;
    logic        tiny;
    logic [52:0] sig;
    logic        left;
    logic [5:0]  amount;
  } dec_t;

  typedef struct packed {
    logic        is_unsigned;
    logic        wide;
    logic        neg;
    logic        nan;
    logic        huge;
    logic [63:0] mag;
  } mag_t;

endpackage

// File: rtl/f2i_if.sv
// Valid/ready channel interface carrying a payload word.
// Depends on nothing; payload type is a parameter.
interface f2i_if #(parameter type payload_t = logic [63:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/float_to_int_saturating_truncate.sv
// Top level of the saturating float-to-integer converter.
// Depends on f2i_pkg, f2i_if, f2i_decode, f2i_shift and f2i_clamp.
// Takes one word per cycle while the pipeline advances and passes it through a
// three-stage pipeline (decode, align shift, clamp) whose stages advance
// together whenever the output register is empty or being taken, so the
// sustained rate is one word per clock while the output is not held off.
module float_to_int_saturating_truncate (
  input logic clk,
  input logic rst,
  f2i_if.sink   in_ch,
  f2i_if.source out_ch
);
  f2i_pkg::dec_t dec_c;
  f2i_pkg::dec_t dec_q;
  f2i_pkg::mag_t mag_c;
  f2i_pkg::mag_t mag_q;
  logic [63:0]   res_c;
  logic [63:0]   res_q;
  logic          v1;
  logic          v2;
  logic          v3;
  logic          advance;

  assign advance = !v3 || out_ch.ready;
  assign in_ch.ready = advance;
  assign out_ch.valid = v3;
  assign out_ch.data = res_q;

  f2i_decode u_dec (.word(in_ch.data), .dec(dec_c));
  f2i_shift  u_shf (.dec(dec_q), .mag(mag_c));
  f2i_clamp  u_clp (.mag(mag_q), .result(res_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_ch.valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (advance) begin
      dec_q <= dec_c;
      mag_q <= mag_c;
      res_q <= res_c;
    end
  end
endmodule

// File: rtl/f2i_decode.sv
// Stage one logic: unpacks the IEEE fields and picks the shift direction and amount.
// Depends on f2i_pkg.
module f2i_decode (
  input  f2i_pkg::in_word_t word,
  output f2i_pkg::dec_t     dec
);
  logic        dbl;
  logic [10:0] exp;
  logic [52:0] sig;
  logic        sgn;
  logic        mzero;
  logic [11:0] e_unb;
  logic        exp_max;
  logic        below;

  always_comb begin
    dbl = word.kind[1];
    if (dbl) begin
      exp   = word.src_bits[62:52];
      sig   = {1'b1, word.src_bits[51:0]};
      sgn   = word.src_bits[63];
      mzero = (word.src_bits[51:0] == 52'd0);
      exp_max = (exp == 11'h7FF);
      below = (exp < 11'd1023);
      e_unb = {1'b0, exp} - 12'd1023;
    end else begin
      exp   = {3'd0, word.src_bits[30:23]};
      sig   = {29'd0, 1'b1, word.src_bits[22:0]};
      sgn   = word.src_bits[31];
      mzero = (word.src_bits[22:0] == 23'd0);
      exp_max = (exp == 11'h0FF);
      below = (exp < 11'd127);
      e_unb = {1'b0, exp} - 12'd127;
    end
    dec.is_unsigned = word.kind[0];
    dec.wide = word.kind[2];
    dec.neg  = sgn;
    dec.nan  = exp_max && !mzero;
    dec.huge = (exp_max && mzero) || (!exp_max && !below && (e_unb >= 12'd64));
    dec.tiny = below && !exp_max;
    dec.sig  = sig;
    if (dbl) begin
      dec.left   = (e_unb >= 12'd52);
      dec.amount = dec.left ? 6'(e_unb - 12'd52) : 6'(12'd52 - e_unb);
    end else begin
      dec.left   = (e_unb >= 12'd23);
      dec.amount = dec.left ? 6'(e_unb - 12'd23) : 6'(12'd23 - e_unb);
    end
  end
endmodule

// File: rtl/f2i_shift.sv
// Stage two logic: aligns the significand into a truncated integer magnitude.
// Depends on f2i_pkg.
module f2i_shift (
  input  f2i_pkg::dec_t dec,
  output f2i_pkg::mag_t mag
);
  logic [63:0] wsig;

  always_comb begin
    wsig = {11'd0, dec.sig};
    mag.is_unsigned = dec.is_unsigned;
    mag.wide = dec.wide;
    mag.neg  = dec.neg;
    mag.nan  = dec.nan;
    mag.huge = dec.huge;
    if (dec.tiny || dec.huge || dec.nan) begin
      mag.mag = 64'd0;
    end else if (dec.left) begin
      mag.mag = wsig << dec.amount;
    end else begin
      mag.mag = wsig >> dec.amount;
    end
  end
endmodule

// File: rtl/f2i_clamp.sv
// Stage three logic: saturates to the target range, applies the sign, NaN gives zero.
// Depends on f2i_pkg.
module f2i_clamp (
  input  f2i_pkg::mag_t mag,
  output logic [63:0]   result
);
  logic [63:0] max_v;
  logic [63:0] min_v;
  logic [63:0] neg_v;

  always_comb begin
    neg_v = 64'd0 - mag.mag;
    if (!mag.wide) neg_v = {32'd0, neg_v[31:0]};
    if (mag.is_unsigned) begin
      max_v = mag.wide ? f2i_pkg::U64_MAX : f2i_pkg::U32_MAX;
      min_v = 64'd0;
    end else begin
      max_v = mag.wide ? f2i_pkg::I64_MAX : f2i_pkg::I32_MAX;
      min_v = mag.wide ? f2i_pkg::I64_MIN : f2i_pkg::I32_MIN;
    end
    priority if (mag.nan) begin
      result = 64'd0;
    end else if (mag.is_unsigned && mag.neg) begin
      result = 64'd0;
    end else if (mag.neg) begin
      result = (mag.huge || mag.mag >= min_v) ? min_v : neg_v;
    end else begin
      result = (mag.huge || mag.mag > max_v) ? max_v : mag.mag;
    end
  end
endmodule

// File: tb/float_to_int_saturating_truncate_test.sv
// Testbench for the saturating float-to-integer converter.
// Drives words through f2i_if channels and checks each result against a local model.
// Depends on f2i_pkg, f2i_if and float_to_int_saturating_truncate.
`timescale 1ns / 1ps

module float_to_int_saturating_truncate_test;

  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   words_sent = 0;
  int   words_checked = 0;
  bit   quiet = 1'b0;
  bit   hold_off = 1'b0;
  logic [63:0] expected_results[$];

  f2i_if #(.payload_t(f2i_pkg::in_word_t)) in_ch ();
  f2i_if #(.payload_t(logic [63:0]))       out_ch ();

  float_to_int_saturating_truncate u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] truncate_saturate(logic [2:0] kind, logic [63:0] bits);
    logic        dbl, wide, uns, neg, nan, huge;
    logic [63:0] mag, max, min_mag, wmask, sig;
    int          ebits, mbits, emax, bias, expo, e;
    dbl = kind[1];
    wide = kind[2];
    uns = kind[0];
    ebits = dbl ? 11 : 8;
    mbits = dbl ? 52 : 23;
    emax = (1 << ebits) - 1;
    bias = emax >> 1;
    if (!dbl) bits = {32'h0, bits[31:0]};
    sig = bits & ((64'd1 << mbits) - 1);
    expo = int'((bits >> mbits) & emax);
    neg = bits[mbits + ebits];
    nan = 1'b0;
    huge = 1'b0;
    mag = '0;
    if (expo == emax) begin
      if (sig != 0) nan = 1'b1;
      else huge = 1'b1;
    end else if (expo >= bias) begin
      e = expo - bias;
      sig = sig | (64'd1 << mbits);
      if (e >= 64) huge = 1'b1;
      else if (e >= mbits) mag = sig << (e - mbits);
      else mag = sig >> (mbits - e);
    end
    if (nan) return '0;
    if (uns) begin
      max = wide ? f2i_pkg::U64_MAX : f2i_pkg::U32_MAX;
      if (neg) return '0;
      if (huge || mag > max) return max;
      return mag;
    end
    max = wide ? f2i_pkg::I64_MAX : f2i_pkg::I32_MAX;
    min_mag = wide ? f2i_pkg::I64_MIN : f2i_pkg::I32_MIN;
    wmask = wide ? f2i_pkg::U64_MAX : f2i_pkg::U32_MAX;
    if (neg) begin
      if (huge || mag >= min_mag) return min_mag;
      return (64'd0 - mag) & wmask;
    end
    if (huge || mag > max) return max;
    return mag;
  endfunction

  task automatic send_word(logic [2:0] kind, logic [63:0] bits);
    while (!quiet && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{kind: kind, src_bits: bits};
    expected_results.push_back(truncate_saturate(kind, bits));
    words_sent++;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_off && (quiet || $urandom_range(99) >= 30);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result %h with nothing expected", $time, out_ch.data);
          mismatches++;
        end else begin
          if (out_ch.data !== expected_results[0]) begin
            $display("%0t: expected %h actual %h", $time, expected_results[0], out_ch.data);
            mismatches++;
          end
          void'(expected_results.pop_front());
          words_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress, %0d results pending", $time, expected_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] random_value(logic dbl);
    logic [63:0] v;
    int          ex;
    v = {$urandom(), $urandom()};
    if ($urandom_range(3) != 0) begin
      if (dbl) begin
        ex = 1023 + $urandom_range(70) - 4;
        v[62:52] = ex[10:0];
      end else begin
        ex = 127 + $urandom_range(70) - 4;
        v[30:23] = ex[7:0];
      end
    end
    return v;
  endfunction

  task automatic test_special_values();
    logic [2:0] k;
    for (int i = 0; i < 8; i++) begin
      k = i[2:0];
      if (k[1]) begin
        send_word(k, 64'h7FF8_0000_0000_0001);
        send_word(k, 64'hFFF0_0000_0000_0000);
        send_word(k, 64'h7FF0_0000_0000_0000);
        send_word(k, 64'h8000_0000_0000_0000);
        send_word(k, 64'hBFEF_FFFF_FFFF_FFFF);
        send_word(k, 64'h0000_0000_0000_0001);
        send_word(k, 64'h41DF_FFFF_FFC0_0000);
        send_word(k, 64'hC1E0_0000_0000_0000);
        send_word(k, 64'h43E0_0000_0000_0000);
        send_word(k, 64'hC3E0_0000_0000_0000);
        send_word(k, 64'h43F0_0000_0000_0000);
      end else begin
        send_word(k, 64'hFFFF_FFFF_FFC0_0001);
        send_word(k, 64'h0000_0000_FF80_0000);
        send_word(k, 64'hABCD_0000_7F80_0000);
        send_word(k, 64'h0000_0000_8000_0000);
        send_word(k, 64'h0000_0000_BF7F_FFFF);
        send_word(k, 64'h0000_0000_0000_0001);
        send_word(k, 64'h0000_0000_4F00_0000);
        send_word(k, 64'h0000_0000_CF00_0000);
        send_word(k, 64'h0000_0000_5F00_0000);
        send_word(k, 64'h0000_0000_DF00_0000);
        send_word(k, 64'h0000_0000_5F80_0000);
      end
    end
    wait_drained();
  endtask

  task automatic test_random_conversions(int count);
    logic [2:0] k;
    for (int i = 0; i < count; i++) begin
      k = 3'($urandom_range(7));
      send_word(k, random_value(k[1]));
    end
  endtask

  task automatic test_back_pressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random_conversions(40);
    join
    wait_drained();
  endtask

  task automatic test_full_rate();
    quiet = 1'b1;
    test_random_conversions(300);
    quiet = 1'b0;
    wait_drained();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_values();
    test_random_conversions(600);
    wait_drained();
    test_back_pressure();
    test_full_rate();
    test_random_conversions(520);
    wait_drained();
    $display("Sent %0d words over all eight kinds, %0d results checked, %0d mismatches.",
             words_sent, words_checked, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: float_to_int_saturating_truncate.f
rtl/f2i_pkg.sv
rtl/f2i_if.sv
rtl/f2i_decode.sv
rtl/f2i_shift.sv
rtl/f2i_clamp.sv
rtl/float_to_int_saturating_truncate.sv
tb/float_to_int_saturating_truncate_test.sv
